>>> design/sor_pkg.sv
// ----------------------------------------------------------------------------
// sor_pkg: shared widths, codes and defaults
// Field widths, request kinds, register indexes and parameter defaults of the
// successive over-relaxation solver.
// ----------------------------------------------------------------------------
package sor_pkg;

  localparam int DATA_W    = 32;
  localparam int KIND_W    = 2;
  localparam int IDX_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int DIM_W     = 5;
  localparam int ITER_W    = 16;
  localparam int RELAX_W   = 18;
  localparam int CFG_DATA_W = 32;

  localparam logic [KIND_W-1:0] KIND_MATRIX   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RHS      = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ESTIMATE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RUN      = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ITERATIONS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELAXATION = 2'd2;

  localparam logic [DIM_W-1:0]   DIMENSION_RESET  = 5'd4;
  localparam logic [ITER_W-1:0]  ITERATIONS_RESET = 16'd1;
  localparam logic [RELAX_W-1:0] RELAXATION_RESET = 18'd65536;

  localparam int DEF_MAX_DIMENSION = 16;
  localparam int DEF_FRACTION_BITS = 16;
  localparam int INDEX_LIMIT       = 16;

endpackage

>>> design/sor_req_if.sv
// ----------------------------------------------------------------------------
// sor_req_if: request channel
// Load and run requests into the solver.
// ----------------------------------------------------------------------------
interface sor_req_if;
  logic                              valid;
  logic                              ready;
  logic [sor_pkg::KIND_W-1:0]        kind;
  logic [sor_pkg::IDX_W-1:0]         row_index;
  logic [sor_pkg::IDX_W-1:0]         column_index;
  logic signed [sor_pkg::DATA_W-1:0] data_value;

  modport source (output valid, kind, row_index, column_index, data_value, input ready);
  modport sink (input valid, kind, row_index, column_index, data_value, output ready);
endinterface

>>> design/sor_rsp_if.sv
// ----------------------------------------------------------------------------
// sor_rsp_if: result channel
// One solved estimate element per result; a run yields one result per unknown.
// ----------------------------------------------------------------------------
interface sor_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [sor_pkg::IDX_W-1:0]         element_index;
  logic signed [sor_pkg::DATA_W-1:0] estimate_value;
  logic                              last_element;
  logic                              zero_diagonal;
  logic                              overflow_flag;

  modport source (output valid, element_index, estimate_value, last_element, zero_diagonal,
                  overflow_flag, input ready);
  modport sink (input valid, element_index, estimate_value, last_element, zero_diagonal,
                overflow_flag, output ready);
endinterface

>>> design/sor_cfg_if.sv
// ----------------------------------------------------------------------------
// sor_cfg_if: configuration write channel
// Register index and write data.
// ----------------------------------------------------------------------------
interface sor_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [sor_pkg::CFG_IDX_W-1:0]     index;
  logic [sor_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> design/sor_ram.sv
// ----------------------------------------------------------------------------
// sor_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module sor_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/sor_linear_solver.sv
// ----------------------------------------------------------------------------
// sor_linear_solver: successive over-relaxation solver, signed fixed point
// Load requests are accepted only while the solver is idle. A run inverts each
// diagonal with a bit-serial reciprocal divider, then sweeps with one matrix
// read per cycle. Each result is offered only after the one before it has been
// accepted by the sink.
// Synchronous reset restores the registers to their defaults; the stores hold
// whatever was last written.
// ----------------------------------------------------------------------------
module sor_linear_solver #(
  parameter int MAX_DIMENSION = sor_pkg::DEF_MAX_DIMENSION,
  parameter int FRACTION_BITS = sor_pkg::DEF_FRACTION_BITS
) (
  input logic       clk,
  input logic       rst,
  sor_req_if.sink   req,
  sor_rsp_if.source rsp,
  sor_cfg_if.sink   cfg
);

  localparam int DW    = sor_pkg::DATA_W;
  localparam int MAW   = $clog2(MAX_DIMENSION * MAX_DIMENSION);
  localparam int VAW   = $clog2(MAX_DIMENSION);
  localparam int DLIM  = (MAX_DIMENSION < sor_pkg::INDEX_LIMIT) ? MAX_DIMENSION
                                                                : sor_pkg::INDEX_LIMIT;
  localparam int NUM_W = (2 * FRACTION_BITS >= 31) ? 2 * FRACTION_BITS + 1 : 32;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam logic [DW-1:0] ONE = DW'(64'd1 << FRACTION_BITS);
  localparam logic [DW-1:0] MAX32 = 32'h7fff_ffff;
  localparam logic [DW-1:0] MIN32 = 32'h8000_0000;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_RCP_RD   = 4'd1;
  localparam logic [3:0] S_RCP_WAIT = 4'd2;
  localparam logic [3:0] S_RCP_DIV  = 4'd3;
  localparam logic [3:0] S_RCP_FIN  = 4'd4;
  localparam logic [3:0] S_ACC      = 4'd5;
  localparam logic [3:0] S_RES      = 4'd6;
  localparam logic [3:0] S_MUL1     = 4'd7;
  localparam logic [3:0] S_TSTEP    = 4'd8;
  localparam logic [3:0] S_MUL2     = 4'd9;
  localparam logic [3:0] S_MUL3     = 4'd10;
  localparam logic [3:0] S_SUM      = 4'd11;
  localparam logic [3:0] S_UPD      = 4'd12;
  localparam logic [3:0] S_OUT_RD   = 4'd13;
  localparam logic [3:0] S_OUT_LD   = 4'd14;
  localparam logic [3:0] S_OUT_WAIT = 4'd15;

  typedef struct packed {
    logic          ov;
    logic [DW-1:0] v;
  } sat32_t;

  typedef struct packed {
    logic        ov;
    logic [63:0] v;
  } sat64_t;

  function automatic sat64_t sat_add64(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    sat64_t r;
    s = {a[63], a} + {b[63], b};
    r.ov = s[64] != s[63];
    if (!r.ov) r.v = s[63:0];
    else if (s[64]) r.v = {1'b1, 63'd0};
    else r.v = {1'b0, {63{1'b1}}};
    return r;
  endfunction

  function automatic logic [63:0] rnd(logic signed [63:0] v);
    return 64'(v >>> FRACTION_BITS) + 64'(v[FRACTION_BITS-1]);
  endfunction

  function automatic sat32_t sat32(logic [63:0] v);
    sat32_t r;
    r.ov = !((&v[63:31]) || !(|v[63:31]));
    if (!r.ov) r.v = v[31:0];
    else if (v[63]) r.v = MIN32;
    else r.v = MAX32;
    return r;
  endfunction

  // configuration
  logic [sor_pkg::DIM_W-1:0]   dimension;
  logic [sor_pkg::ITER_W-1:0]  iteration_count;
  logic [sor_pkg::RELAX_W-1:0] relaxation_factor;

  localparam int ITER_W_L = sor_pkg::ITER_W;
  logic [3:0]          state;
  logic [4:0]          ic;
  logic [4:0]          jc;
  logic [ITER_W_L-1:0] sweep;
  logic                v1;
  logic                v2;
  logic [4:0]          j1;
  logic                skip2;
  logic [63:0]         acc;
  logic [63:0]         prod;
  logic [63:0]         pa;
  logic [63:0]         sum;
  logic [DW-1:0]       xi;
  logic [DW-1:0]       res;
  logic [DW-1:0]       tval;
  logic                zero_seen;
  logic                ov_seen;

  logic [NUM_W-1:0]    dnum;
  logic [DW-1:0]       drem;
  logic [DW-1:0]       dmag;
  logic                dneg;
  logic [CNT_W-1:0]    dcnt;

  logic                out_valid;
  logic [sor_pkg::IDX_W-1:0] out_index;
  logic [DW-1:0]       out_value;
  logic                out_last;
  logic                out_zero;
  logic                out_ov;

  // memory ports
  logic           m_we, m_re, e_we, e_re, b_we, b_re, r_we, r_re;
  logic [MAW-1:0] m_waddr, m_raddr;
  logic [VAW-1:0] e_waddr, e_raddr, b_waddr, v_raddr, r_waddr;
  logic [DW-1:0]  e_wdata, r_wdata;
  logic [DW-1:0]  m_rd, e_rd, b_rd, r_rd;

  logic [4:0]       d_eff;
  logic             req_acc;
  logic             issuing;
  logic             row_ok, col_ok;
  logic [DW-1:0]    one_minus_w;
  logic [DW-1:0]    mul_a, mul_b;
  logic [DW-1:0]    diag_mag;
  logic [DW:0]      rem2;
  logic             rem_ge;
  logic [DW-1:0]    rcp_val;
  logic             rcp_ov;
  sat64_t           acc_add, sum_add;
  sat32_t           res_sat, t_sat, upd_sat;

  assign d_eff = (dimension == '0) ? 5'd1 :
                 (32'(dimension) > DLIM) ? 5'(DLIM) : dimension;
  assign req.ready = (state == S_IDLE);
  assign req_acc   = req.valid && req.ready;
  assign cfg.ready = 1'b1;
  assign issuing   = (state == S_ACC) && (jc < d_eff);
  assign row_ok    = 32'(req.row_index) < MAX_DIMENSION;
  assign col_ok    = 32'(req.column_index) < MAX_DIMENSION;
  assign one_minus_w = ONE - DW'(relaxation_factor);
  assign diag_mag  = m_rd[DW-1] ? (~m_rd + 1'b1) : m_rd;

  // restoring divider step
  assign rem2   = {drem, dnum[NUM_W-1]};
  assign rem_ge = rem2 >= {1'b0, dmag};

  always_comb begin
    rcp_ov  = 1'b0;
    rcp_val = dnum[DW-1:0];
    if (!dneg) begin
      if (64'(dnum) > 64'(MAX32)) begin
        rcp_ov  = 1'b1;
        rcp_val = MAX32;
      end
    end else if (64'(dnum) > 64'(MIN32)) begin
      rcp_ov  = 1'b1;
      rcp_val = MIN32;
    end else begin
      rcp_val = ~dnum[DW-1:0] + 1'b1;
    end
  end

  always_comb begin
    case (state)
      S_MUL1:  begin mul_a = r_rd;        mul_b = res;  end
      S_MUL2:  begin mul_a = one_minus_w; mul_b = xi;   end
      S_MUL3:  begin mul_a = DW'(relaxation_factor); mul_b = tval; end
      default: begin mul_a = m_rd;        mul_b = e_rd; end
    endcase
  end

  assign acc_add = sat_add64(acc, ~prod + 64'd1);
  assign sum_add = sat_add64(pa, prod);
  assign res_sat = sat32(rnd(acc));
  assign t_sat   = sat32(rnd(prod));
  assign upd_sat = sat32(rnd(sum));

  always_comb begin
    m_we    = req_acc && (req.kind == sor_pkg::KIND_MATRIX) && row_ok && col_ok;
    m_waddr = MAW'(32'(req.row_index) * MAX_DIMENSION + 32'(req.column_index));
    m_re    = issuing || (state == S_RCP_RD);
    m_raddr = (state == S_RCP_RD) ? MAW'(32'(ic) * MAX_DIMENSION + 32'(ic))
                                  : MAW'(32'(ic) * MAX_DIMENSION + 32'(jc));
    b_we    = req_acc && (req.kind == sor_pkg::KIND_RHS) && row_ok;
    b_waddr = VAW'(req.row_index);
    b_re    = issuing && (jc == '0);
    r_re    = b_re;
    v_raddr = VAW'(ic);
    e_we    = (req_acc && (req.kind == sor_pkg::KIND_ESTIMATE) && row_ok)
              || (state == S_UPD);
    e_waddr = (state == S_UPD) ? VAW'(ic) : VAW'(req.row_index);
    e_wdata = (state == S_UPD) ? upd_sat.v : req.data_value;
    e_re    = issuing || (state == S_OUT_RD);
    e_raddr = (state == S_OUT_RD) ? VAW'(ic) : VAW'(jc);
    r_we    = ((state == S_RCP_WAIT) && (m_rd == '0)) || (state == S_RCP_FIN);
    r_waddr = VAW'(ic);
    r_wdata = (state == S_RCP_FIN) ? rcp_val : MAX32;
  end

  sor_ram #(.WIDTH(DW), .DEPTH(MAX_DIMENSION * MAX_DIMENSION)) u_matrix (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(req.data_value),
    .re(m_re), .raddr(m_raddr), .rdata(m_rd)
  );

  sor_ram #(.WIDTH(DW), .DEPTH(MAX_DIMENSION)) u_rhs (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(req.data_value),
    .re(b_re), .raddr(v_raddr), .rdata(b_rd)
  );

  sor_ram #(.WIDTH(DW), .DEPTH(MAX_DIMENSION)) u_estimate (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .re(e_re), .raddr(e_raddr), .rdata(e_rd)
  );

  sor_ram #(.WIDTH(DW), .DEPTH(MAX_DIMENSION)) u_recip (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .re(r_re), .raddr(v_raddr), .rdata(r_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension         <= sor_pkg::DIMENSION_RESET;
      iteration_count   <= sor_pkg::ITERATIONS_RESET;
      relaxation_factor <= sor_pkg::RELAXATION_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        sor_pkg::CFG_DIMENSION:  dimension <= cfg.data[sor_pkg::DIM_W-1:0];
        sor_pkg::CFG_ITERATIONS: iteration_count <= cfg.data[sor_pkg::ITER_W-1:0];
        sor_pkg::CFG_RELAXATION: relaxation_factor <= cfg.data[sor_pkg::RELAX_W-1:0];
        default: ;
      endcase
    end
  end

  // residual pipeline: read, multiply, accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= issuing;
      v2 <= v1;
    end
    j1 <= jc;
    if (v1) begin
      skip2 <= (j1 == ic);
      if (j1 == ic) xi <= e_rd;
    end
    if (state == S_ACC || state == S_MUL1 || state == S_MUL2 || state == S_MUL3) begin
      prod <= 64'($signed(mul_a) * $signed(mul_b));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      ic        <= '0;
      jc        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_acc && req.kind == sor_pkg::KIND_RUN) begin
            zero_seen <= 1'b0;
            ov_seen   <= 1'b0;
            ic        <= '0;
            state     <= S_RCP_RD;
          end
        end
        S_RCP_RD: state <= S_RCP_WAIT;
        S_RCP_WAIT: begin
          dmag <= diag_mag;
          dneg <= m_rd[DW-1];
          drem <= '0;
          dcnt <= '0;
          dnum <= NUM_W'((64'd1 << (2 * FRACTION_BITS)) + 64'(diag_mag >> 1));
          if (m_rd == '0) begin
            zero_seen <= 1'b1;
            if (ic == d_eff - 5'd1) begin
              ic    <= '0;
              jc    <= '0;
              sweep <= '0;
              state <= (iteration_count == '0) ? S_OUT_RD : S_ACC;
            end else begin
              ic    <= ic + 5'd1;
              state <= S_RCP_RD;
            end
          end else begin
            state <= S_RCP_DIV;
          end
        end
        S_RCP_DIV: begin
          drem <= rem_ge ? DW'(rem2 - {1'b0, dmag}) : rem2[DW-1:0];
          dnum <= {dnum[NUM_W-2:0], rem_ge};
          dcnt <= dcnt + 1'b1;
          if (dcnt == CNT_W'(NUM_W - 1)) state <= S_RCP_FIN;
        end
        S_RCP_FIN: begin
          if (rcp_ov) ov_seen <= 1'b1;
          if (ic == d_eff - 5'd1) begin
            ic    <= '0;
            jc    <= '0;
            sweep <= '0;
            state <= (iteration_count == '0) ? S_OUT_RD : S_ACC;
          end else begin
            ic    <= ic + 5'd1;
            state <= S_RCP_RD;
          end
        end
        S_ACC: begin
          if (issuing) jc <= jc + 5'd1;
          if (v1 && j1 == '0) acc <= {{(64 - DW - FRACTION_BITS){b_rd[DW-1]}}, b_rd,
                                      {FRACTION_BITS{1'b0}}};
          if (v2 && !skip2) begin
            acc <= acc_add.v;
            if (acc_add.ov) ov_seen <= 1'b1;
          end
          if (!issuing && !v1 && !v2) state <= S_RES;
        end
        S_RES: begin
          res <= res_sat.v;
          if (res_sat.ov) ov_seen <= 1'b1;
          state <= S_MUL1;
        end
        S_MUL1: state <= S_TSTEP;
        S_TSTEP: begin
          tval <= t_sat.v;
          if (t_sat.ov) ov_seen <= 1'b1;
          state <= S_MUL2;
        end
        S_MUL2: state <= S_MUL3;
        S_MUL3: begin
          pa    <= prod;
          state <= S_SUM;
        end
        S_SUM: begin
          sum <= sum_add.v;
          if (sum_add.ov) ov_seen <= 1'b1;
          state <= S_UPD;
        end
        S_UPD: begin
          if (upd_sat.ov) ov_seen <= 1'b1;
          jc <= '0;
          if (ic != d_eff - 5'd1) begin
            ic    <= ic + 5'd1;
            state <= S_ACC;
          end else begin
            ic <= '0;
            if (sweep == iteration_count - 1'b1) begin
              state <= S_OUT_RD;
            end else begin
              sweep <= sweep + 1'b1;
              state <= S_ACC;
            end
          end
        end
        S_OUT_RD: state <= S_OUT_LD;
        S_OUT_LD: begin
          out_valid <= 1'b1;
          out_index <= sor_pkg::IDX_W'(ic);
          out_value <= e_rd;
          out_last  <= (ic == d_eff - 5'd1);
          out_zero  <= zero_seen;
          out_ov    <= ov_seen;
          state     <= S_OUT_WAIT;
        end
        S_OUT_WAIT: begin
          if (rsp.ready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              state <= S_IDLE;
            end else begin
              ic    <= ic + 5'd1;
              state <= S_OUT_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.element_index  = out_index;
  assign rsp.estimate_value = out_value;
  assign rsp.last_element   = out_last;
  assign rsp.zero_diagonal  = out_zero;
  assign rsp.overflow_flag  = out_ov;

endmodule

>>> bench/sor_solver_checker.sv
// ----------------------------------------------------------------------------
// sor_solver_checker: result predictor and scoreboard
// Watches the request, config and result channels of the SOR solver. It keeps
// its own copy of the stores and registers and works out each run's estimates.
// Every accepted result is compared field by field with the oldest one
// predicted.
// ----------------------------------------------------------------------------
module sor_solver_checker
  import sor_pkg::*;
(
  input  logic clk,
  input  logic rst,
  sor_req_if   req,
  sor_rsp_if   rsp,
  sor_cfg_if   cfg,
  output int   error_count,
  output int   pending_count
);

  localparam int  FB      = DEF_FRACTION_BITS;
  localparam int  MAXD    = DEF_MAX_DIMENSION;
  localparam longint ONE  = longint'(1) << FB;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [IDX_W-1:0]         element_index;
    logic signed [DATA_W-1:0] estimate_value;
    logic                     last_element;
    logic                     zero_diagonal;
    logic                     overflow_flag;
  } estimate_t;

  int  mat_q [MAXD*MAXD];
  int  rhs_q [MAXD];
  int  est_q [MAXD];
  int  recip_q [MAXD];
  logic [DIM_W-1:0]   dim_reg;
  logic [ITER_W-1:0]  iter_reg;
  logic [RELAX_W-1:0] relax_reg;
  estimate_t expected_estimates[$];

  assign pending_count = expected_estimates.size();

  function automatic longint add_sat(input longint a, input longint b, inout bit ov);
    longint s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      ov = 1;
      return a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s;
  endfunction

  function automatic int clip32(input longint v, inout bit ov);
    if (v > S32_MAX) begin
      ov = 1;
      return int'(S32_MAX);
    end
    if (v < S32_MIN) begin
      ov = 1;
      return int'(S32_MIN);
    end
    return int'(v);
  endfunction

  // round half up: arithmetic shift plus the highest dropped bit
  function automatic longint round_q(input longint v);
    return (v >>> FB) + longint'(v[FB-1]);
  endfunction

  function automatic int invert_diag(input int a, inout bit zero, inout bit ov);
    longint unsigned mag, q;
    if (a == 0) begin
      zero = 1;
      return int'(S32_MAX);
    end
    mag = (a < 0) ? longint'(-longint'(a)) : longint'(a);
    q = ((longint'(1) << (2 * FB)) + mag / 2) / mag;
    if (a > 0) begin
      if (q > longint'(S32_MAX)) begin
        ov = 1;
        return int'(S32_MAX);
      end
      return int'(q);
    end
    if (q > 64'h8000_0000) begin
      ov = 1;
      return int'(S32_MIN);
    end
    return int'(-longint'(q));
  endfunction

  task automatic solve_run();
    int d, res, step;
    bit zero, ov;
    longint acc, sum, w;
    estimate_t e;
    zero = 0;
    ov = 0;
    w = longint'(relax_reg);
    d = int'(dim_reg);
    if (d > MAXD) d = MAXD;
    if (d > INDEX_LIMIT) d = INDEX_LIMIT;
    if (d < 1) d = 1;
    for (int i = 0; i < d; i++) recip_q[i] = invert_diag(mat_q[i*MAXD+i], zero, ov);
    for (int it = 0; it < int'(iter_reg); it++) begin
      for (int i = 0; i < d; i++) begin
        acc = longint'(rhs_q[i]) * ONE;
        for (int j = 0; j < d; j++) begin
          if (j != i) acc = add_sat(acc, -(longint'(mat_q[i*MAXD+j]) * longint'(est_q[j])), ov);
        end
        res  = clip32(round_q(acc), ov);
        step = clip32(round_q(longint'(recip_q[i]) * longint'(res)), ov);
        sum  = add_sat((ONE - w) * longint'(est_q[i]), w * longint'(step), ov);
        est_q[i] = clip32(round_q(sum), ov);
      end
    end
    for (int i = 0; i < d; i++) begin
      e.element_index  = IDX_W'(i);
      e.estimate_value = est_q[i];
      e.last_element   = (i == d - 1);
      e.zero_diagonal  = zero;
      e.overflow_flag  = ov;
      expected_estimates.push_back(e);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      dim_reg     <= DIMENSION_RESET;
      iter_reg    <= ITERATIONS_RESET;
      relax_reg   <= RELAXATION_RESET;
      error_count <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_DIMENSION:  dim_reg   <= cfg.data[DIM_W-1:0];
          CFG_ITERATIONS: iter_reg  <= cfg.data[ITER_W-1:0];
          CFG_RELAXATION: relax_reg <= cfg.data[RELAX_W-1:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        case (req.kind)
          KIND_MATRIX:   mat_q[int'(req.row_index)*MAXD + int'(req.column_index)] = req.data_value;
          KIND_RHS:      rhs_q[req.row_index] = req.data_value;
          KIND_ESTIMATE: est_q[req.row_index] = req.data_value;
          default:       solve_run();
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_estimates.size() == 0) begin
          $error("unexpected result: element_index %0d value %0d", rsp.element_index,
                 rsp.estimate_value);
          error_count <= error_count + 1;
        end else begin
          estimate_t e;
          e = expected_estimates.pop_front();
          if (rsp.element_index !== e.element_index ||
              rsp.estimate_value !== e.estimate_value ||
              rsp.last_element !== e.last_element || rsp.zero_diagonal !== e.zero_diagonal ||
              rsp.overflow_flag !== e.overflow_flag)
            error_count <= error_count + 1;
          if (rsp.element_index !== e.element_index)
            $error("element_index: expected %0d, got %0d", e.element_index, rsp.element_index);
          if (rsp.estimate_value !== e.estimate_value)
            $error("estimate_value: expected %0d, got %0d", e.estimate_value,
                   rsp.estimate_value);
          if (rsp.last_element !== e.last_element)
            $error("last_element: expected %0b, got %0b", e.last_element, rsp.last_element);
          if (rsp.zero_diagonal !== e.zero_diagonal)
            $error("zero_diagonal: expected %0b, got %0b", e.zero_diagonal, rsp.zero_diagonal);
          if (rsp.overflow_flag !== e.overflow_flag)
            $error("overflow_flag: expected %0b, got %0b", e.overflow_flag, rsp.overflow_flag);
        end
      end
    end
  end

endmodule

>>> bench/tb_sor_linear_solver.sv
// ----------------------------------------------------------------------------
// tb_sor_linear_solver: stimulus and verdict for the SOR solver
// Loads well-conditioned systems and noisy ones, runs them under several
// register settings and traffic patterns, and lets the checker judge results.
// ----------------------------------------------------------------------------
module tb_sor_linear_solver;
  import sor_pkg::*;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int LONG_HOLD   = 600;

  logic clk;
  logic rst;
  int   error_count;
  int   pending_count;
  int   cycle_count = 0;
  int   send_idle_pct;
  int   recv_stall_pct;
  bit   hold_wanted;
  bit   hold_done = 1'b0;
  int   hold_cycles = 0;
  int   cur_dim;

  sor_req_if req_ch();
  sor_rsp_if rsp_ch();
  sor_cfg_if cfg_ch();

  sor_linear_solver u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source),
    .cfg (cfg_ch.sink)
  );

  sor_solver_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .req           (req_ch),
    .rsp           (rsp_ch),
    .cfg           (cfg_ch),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result sink: random stall, plus one long hold-off while requests keep coming
  always @(posedge clk) begin
    if (hold_wanted && !hold_done) begin
      rsp_ch.ready <= 1'b0;
      hold_cycles  <= hold_cycles + 1;
      if (hold_cycles == LONG_HOLD) hold_done <= 1'b1;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_request(input logic [KIND_W-1:0] kind, input int row, input int col,
                              input int value);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.kind         <= kind;
    req_ch.row_index    <= IDX_W'(row);
    req_ch.column_index <= IDX_W'(col);
    req_ch.data_value   <= value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic drop_request();
    req_ch.valid <= 1'b0;
  endtask

  // wait for every estimate, then let the block settle before a register write
  task automatic drain();
    drop_request();
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic configure(input int dim, input int iters, input int relax);
    write_reg(CFG_DIMENSION, 32'(dim) | ($urandom & 32'hFFFF_FFE0));
    write_reg(CFG_ITERATIONS, 32'(iters) | ($urandom & 32'hFFFF_0000));
    write_reg(CFG_RELAXATION, 32'(relax) | ($urandom & 32'hFFFC_0000));
    cur_dim = (dim < 1) ? 1 : (dim > 16 ? 16 : dim);
  endtask

  // system of size n with random content and large diagonal entries, then run
  task automatic load_system(input int n);
    int sgn;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        sgn = $urandom_range(1) ? 1 : -1;
        if (i == j)
          send_request(KIND_MATRIX, i, j, sgn * int'($urandom_range(20 << 16, 2 << 16)));
        else
          send_request(KIND_MATRIX, i, j, sgn * int'($urandom_range(1 << 16)));
      end
      send_request(KIND_RHS, i, 0, int'($urandom_range(1 << 20)) - (1 << 19));
      send_request(KIND_ESTIMATE, i, $urandom_range(15), int'($urandom_range(1 << 18)) - (1 << 17));
    end
    send_request(KIND_RUN, $urandom_range(15), $urandom_range(15), $urandom);
  endtask

  task automatic noise_request();
    send_request(KIND_W'($urandom_range(3)), $urandom_range(15), $urandom_range(15), $urandom);
  endtask

  task automatic random_phase(input int idle, input int stall, input int count);
    int sent;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(3) != 0) begin
        load_system(cur_dim);
        sent += cur_dim * (cur_dim + 2) + 1;
      end else begin
        noise_request();
        sent++;
      end
    end
    drain();
  endtask

  initial begin
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.kind <= KIND_MATRIX;
    req_ch.row_index <= '0;
    req_ch.column_index <= '0;
    req_ch.data_value <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_DIMENSION;
    cfg_ch.data <= '0;
    hold_wanted = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cur_dim = 4;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // fill every entry that a run of up to four unknowns reads
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++)
        send_request(KIND_MATRIX, i, j, (i == j) ? 32'sd262144 : int'($urandom_range(65535)));
      send_request(KIND_RHS, i, 0, int'($urandom_range(1 << 18)));
      send_request(KIND_ESTIMATE, i, 0, 0);
    end
    // run with register defaults
    send_request(KIND_RUN, 0, 0, 0);
    // zero diagonal, then extreme values that saturate
    send_request(KIND_MATRIX, 1, 1, 0);
    send_request(KIND_RUN, 15, 15, -1);
    send_request(KIND_MATRIX, 0, 0, 32'sh7FFF_FFFF);
    send_request(KIND_MATRIX, 0, 1, 32'sh8000_0000);
    send_request(KIND_MATRIX, 1, 1, 1);
    send_request(KIND_MATRIX, 2, 2, -1);
    send_request(KIND_MATRIX, 3, 3, 32'sh8000_0000);
    send_request(KIND_RHS, 0, 15, 32'sh7FFF_FFFF);
    send_request(KIND_RHS, 3, 0, 32'sh8000_0000);
    send_request(KIND_ESTIMATE, 1, 0, 32'sh8000_0000);
    send_request(KIND_ESTIMATE, 2, 0, 32'sh7FFF_FFFF);
    send_request(KIND_RUN, 0, 0, 0);
    drain();

    // zero sweeps and dimension below range, unknown register index
    configure(0, 0, 0);
    write_reg(CFG_IDX_W'(3), $urandom);
    send_request(KIND_RUN, 0, 0, 0);
    drain();
    // many sweeps on a single unknown
    configure(1, 65535, 98304);
    send_request(KIND_MATRIX, 0, 0, 32'sh0003_0000);
    send_request(KIND_RUN, 0, 0, 0);
    drain();

    configure(4, 2, 65536);
    random_phase(0, 0, 20);
    configure(2, 1, 131072);
    random_phase(86, 0, 12);
    configure(3, 3, 0);
    random_phase(0, 86, 12);
    configure(4, 1, 80000);
    random_phase(33, 33, 12);

    // long sink hold-off while two runs are offered
    configure(3, 2, 262143);
    recv_stall_pct = 0;
    send_idle_pct = 0;
    hold_wanted = 1'b1;
    repeat (2) load_system(3);
    drain();
    configure(2, 2, 70000);
    random_phase(0, 0, 10);

    repeat (100) @(posedge clk);
    if (error_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
